@@ rtl/cocd_pkg.sv @@
// ----------------------------------------------------------------------------
// cocd_pkg: shared types and constants for the chain oiler mode core
// Item, result, state and register-set types, with the codes they carry.
// ----------------------------------------------------------------------------
package cocd_pkg;

    localparam int DIST_W     = 32;
    localparam int STEP_W     = 16;
    localparam int PRESS_W    = 40;
    localparam int INTERVAL_W = 30;
    localparam int COUNT_W    = 8;
    localparam int LONG_W     = 26;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 30;
    localparam int IN_DATA_W  = 64;
    localparam int OUT_DATA_W = 16;
    localparam int RESULT_W   = 15;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_CROSS  = 2'd1,
        MODE_RAIN   = 2'd2,
        MODE_AP     = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_TACHO  = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_CHECK  = 2'd2,
        KIND_NOP    = 2'd3
    } kind_t;

    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_SHORT = 2'd1;
    localparam logic [1:0] ACT_LONG  = 2'd2;

    localparam logic [1:0] LED_NONE    = 2'd0;
    localparam logic [1:0] LED_CONTROL = 2'd1;
    localparam logic [1:0] LED_CROSS   = 2'd2;

    localparam logic [1:0] AP_NONE    = 2'd0;
    localparam logic [1:0] AP_ENTERED = 2'd1;
    localparam logic [1:0] AP_LEFT    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_OIL_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NORMAL_COUNT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CROSS_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RAIN_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd4;

    localparam logic [INTERVAL_W-1:0] RST_OIL_INTERVAL = 30'd50000000;
    localparam logic [COUNT_W-1:0]    RST_NORMAL_COUNT = 8'd2;
    localparam logic [COUNT_W-1:0]    RST_CROSS_COUNT  = 8'd4;
    localparam logic [COUNT_W-1:0]    RST_RAIN_COUNT   = 8'd3;
    localparam logic [LONG_W-1:0]     RST_LONG_PRESS   = 26'd2000000;

    typedef struct packed {
        logic [INTERVAL_W-1:0] oil_interval_mm;
        logic [COUNT_W-1:0]    normal_pump_count;
        logic [COUNT_W-1:0]    cross_pump_count;
        logic [COUNT_W-1:0]    rain_pump_count;
        logic [LONG_W-1:0]     long_press_us;
    } cfg_t;

    typedef struct packed {
        kind_t              kind;
        logic [STEP_W-1:0]  distance_mm;
        logic [1:0]         control_action;
        logic               rain_click;
        logic [PRESS_W-1:0] press_time_us;
    } item_t;

    typedef struct packed {
        mode_t             op_mode;
        logic [DIST_W-1:0] distance_since_oil;
        logic              attention_flag;
        logic              rain_pending;
    } state_t;

    // last member sits in the low bits, so this packs straight into tdata
    typedef struct packed {
        logic [1:0]         ap_change;
        logic [1:0]         led_flash;
        logic [COUNT_W-1:0] pump_strokes;
        logic               attention;
        mode_t              mode;
    } result_t;

endpackage

@@ rtl/chain_oiler_mode_and_dispense_core.sv @@
// ----------------------------------------------------------------------------
// chain_oiler_mode_and_dispense_core: chain oiler mode and dispense controller
// Tracks mode, distance since oiling, attention and a pending rain click.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_*: one item per transfer; tuser carries the item kind
//   (tacho, button poll, oil-check tick), tdata the remaining fields.
//   Output stream m_*: exactly one result per input item, in order, giving
//   mode, attention flag, pump strokes, LED flash and access-point change.
//   Config port: cfg_we writes cfg_data into register cfg_index; indexes
//   beyond the register list are ignored. Write only while the core is idle.
//   Path: an item lands in the input register at its transfer, and the
//   update logic loads its result into the result register once that
//   register is empty or being drained (m_tready high).
//   Throughput: one item per cycle while m_tready stays high; the controller
//   state is updated as an item moves from the input to the result register.
//   Stall: while m_tready is low the result holds, one more item waits in
//   the input register, and s_tready drops only when both are full.
//   Reset: rst_n clears both stages, puts the controller in normal mode with
//   zero distance, and loads the register defaults.
// ----------------------------------------------------------------------------
module chain_oiler_mode_and_dispense_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // distance_mm[15:0], control_action[17:16], rain_click[18],
    // press_time_us[58:19], zero fill [63:59]
    input  logic [cocd_pkg::IN_DATA_W-1:0]  s_tdata,
    // kind[1:0]
    input  logic [1:0]                       s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // mode[1:0], attention[2], pump_strokes[10:3], led_flash[12:11],
    // ap_change[14:13], zero fill [15]
    output logic [cocd_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                             cfg_we,
    input  logic [cocd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cocd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cocd_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_vld_reg;
    logic    out_vld_reg;
    result_t result_reg;
    result_t result_next;
    state_t  state_reg;
    state_t  state_next;
    logic    advance;
    logic    s_xfer;

    cocd_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cocd_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (result_next)
    );

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg                   <= 1'b0;
            out_vld_reg                  <= 1'b0;
            state_reg.op_mode            <= MODE_NORMAL;
            state_reg.distance_since_oil <= '0;
            state_reg.attention_flag     <= 1'b0;
            state_reg.rain_pending       <= 1'b0;
        end
        else
        begin
            if (s_xfer)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            item_reg.kind           <= kind_t'(s_tuser);
            item_reg.distance_mm    <= s_tdata[15:0];
            item_reg.control_action <= s_tdata[17:16];
            item_reg.rain_click     <= s_tdata[18];
            item_reg.press_time_us  <= s_tdata[58:19];
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(OUT_DATA_W-RESULT_W){1'b0}}, result_reg};

endmodule

@@ rtl/cocd_cfg.sv @@
// ----------------------------------------------------------------------------
// cocd_cfg: configuration register file
// Holds the oil interval, the three pump counts and the long-press time.
// ----------------------------------------------------------------------------
module cocd_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cocd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cocd_pkg::CFG_DATA_W-1:0] cfg_data,
    output cocd_pkg::cfg_t                   cfg
);
    import cocd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.oil_interval_mm   <= RST_OIL_INTERVAL;
            cfg_reg.normal_pump_count <= RST_NORMAL_COUNT;
            cfg_reg.cross_pump_count  <= RST_CROSS_COUNT;
            cfg_reg.rain_pump_count   <= RST_RAIN_COUNT;
            cfg_reg.long_press_us     <= RST_LONG_PRESS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_OIL_INTERVAL: cfg_reg.oil_interval_mm   <= cfg_data[INTERVAL_W-1:0];
                REG_NORMAL_COUNT: cfg_reg.normal_pump_count <= cfg_data[COUNT_W-1:0];
                REG_CROSS_COUNT:  cfg_reg.cross_pump_count  <= cfg_data[COUNT_W-1:0];
                REG_RAIN_COUNT:   cfg_reg.rain_pump_count   <= cfg_data[COUNT_W-1:0];
                REG_LONG_PRESS:   cfg_reg.long_press_us     <= cfg_data[LONG_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/cocd_step.sv @@
// ----------------------------------------------------------------------------
// cocd_step: per-item update logic
// Computes the next controller state and the result for one item.
// ----------------------------------------------------------------------------
module cocd_step (
    input  cocd_pkg::cfg_t    cfg,
    input  cocd_pkg::state_t  state,
    input  cocd_pkg::item_t   item,
    output cocd_pkg::state_t  state_next,
    output cocd_pkg::result_t result
);
    import cocd_pkg::*;

    logic [DIST_W:0]    dist_sum;
    logic [PRESS_W-1:0] long_ext;
    logic               press_zero;
    logic               rain_now;
    logic               deferred;
    logic               oil_due;
    logic [COUNT_W-1:0] pump;
    logic [1:0]         led;
    logic [1:0]         ap;
    state_t             s;

    assign dist_sum   = {1'b0, state.distance_since_oil} + {{(DIST_W+1-STEP_W){1'b0}}, item.distance_mm};
    assign long_ext   = {{(PRESS_W-LONG_W){1'b0}}, cfg.long_press_us};
    assign press_zero = (item.press_time_us == '0);
    assign rain_now   = item.rain_click | state.rain_pending;
    assign oil_due    = (state.op_mode != MODE_AP) &&
                        (state.distance_since_oil > {{(DIST_W-INTERVAL_W){1'b0}}, cfg.oil_interval_mm});

    always_comb
    begin
        s        = state;
        pump     = '0;
        led      = LED_NONE;
        ap       = AP_NONE;
        deferred = 1'b0;

        case (item.kind)
            KIND_TACHO:
            begin
                if (state.op_mode != MODE_AP)
                begin
                    s.distance_since_oil = dist_sum[DIST_W] ? '1 : dist_sum[DIST_W-1:0];
                end
            end
            KIND_BUTTON:
            begin
                // hysteresis: equal to the threshold keeps the flag
                if (!state.attention_flag && !press_zero && item.press_time_us > long_ext)
                begin
                    s.attention_flag = 1'b1;
                end
                else if (state.attention_flag && (press_zero || item.press_time_us < long_ext))
                begin
                    s.attention_flag = 1'b0;
                end

                if (item.control_action == ACT_SHORT)
                begin
                    if (state.op_mode == MODE_AP)
                    begin
                        s.op_mode      = MODE_NORMAL;
                        ap             = AP_LEFT;
                        s.rain_pending = rain_now;
                        deferred       = 1'b1;
                    end
                    else if (state.op_mode == MODE_CROSS)
                    begin
                        s.op_mode = MODE_NORMAL;
                        led       = LED_CONTROL;
                    end
                    else
                    begin
                        s.op_mode = MODE_CROSS;
                        led       = LED_CROSS;
                    end
                end
                else if (item.control_action == ACT_LONG)
                begin
                    if (state.op_mode == MODE_AP)
                    begin
                        s.op_mode = MODE_NORMAL;
                        ap        = AP_LEFT;
                    end
                    else
                    begin
                        s.op_mode = MODE_AP;
                        ap        = AP_ENTERED;
                    end
                end

                if (!deferred && rain_now)
                begin
                    if (s.op_mode == MODE_NORMAL)
                    begin
                        s.op_mode = MODE_RAIN;
                    end
                    else if (s.op_mode == MODE_RAIN)
                    begin
                        s.op_mode = MODE_NORMAL;
                    end
                    s.rain_pending = 1'b0;
                end
            end
            KIND_CHECK:
            begin
                if (oil_due)
                begin
                    case (state.op_mode)
                        MODE_CROSS: pump = cfg.cross_pump_count;
                        MODE_RAIN:  pump = cfg.rain_pump_count;
                        default:    pump = cfg.normal_pump_count;
                    endcase
                    s.distance_since_oil = '0;
                end
            end
            default: ;
        endcase
    end

    assign state_next          = s;
    assign result.mode         = s.op_mode;
    assign result.attention    = s.attention_flag;
    assign result.pump_strokes = pump;
    assign result.led_flash    = led;
    assign result.ap_change    = ap;

endmodule

@@ rtl/cocd_checker.sv @@
// ----------------------------------------------------------------------------
// cocd_checker: port-level checks for the chain oiler mode core
// Watches the result stream and checks consistency of reported fields.
// ----------------------------------------------------------------------------
module cocd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [cocd_pkg::OUT_DATA_W-1:0] m_tdata
);
    import cocd_pkg::*;

    result_t res;

    assign res = result_t'(m_tdata[RESULT_W-1:0]);

    // a held result keeps its payload
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // strokes come only from an oil check, which never flashes or toggles AP
    a_pump_alone: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.pump_strokes != '0 |->
            res.led_flash == LED_NONE && res.ap_change == AP_NONE && res.mode != MODE_AP)
        else $error("pump strokes with button activity or in access point");

    a_ap_enter: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.ap_change == AP_ENTERED |-> res.mode == MODE_AP)
        else $error("access point entered but mode differs");

    a_ap_leave: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.ap_change == AP_LEFT |-> res.mode != MODE_AP && res.led_flash == LED_NONE)
        else $error("access point left but still in access point");

    a_cross_led: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.led_flash == LED_CROSS |-> res.mode == MODE_CROSS)
        else $error("cross LED flash outside cross mode");

endmodule

bind chain_oiler_mode_and_dispense_core cocd_checker u_cocd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
